// File: hw/rtl/mcl_pkg.sv
// Shared types, constants and month tables for the month calendar layout block.
// Used by mcl_mod_unit, mcl_day_gen and month_calendar_layout. No dependencies.
`timescale 1ns / 1ps

package mcl_pkg;

    // Widths of the transaction fields.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int ROW_W    = 3;
    localparam int REM_W    = 9;

    // Reciprocal multiplication in the remainder unit: the quotient of a value
    // below 2^YEAR_W is (value * reciprocal) >> RECIP_SHIFT, exact for both divisors.
    localparam int RECIP_W     = 19;
    localparam int QUOT_W      = 12;
    localparam int RECIP_SHIFT = 21;

    // Constants of the Gregorian rules.
    localparam logic [REM_W-1:0]   CYCLE_DAYS  = 9'd400;
    localparam logic [REM_W-1:0]   WEEK_DAYS   = 9'd7;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd11;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd1;
    localparam logic [WDAY_W-1:0]  LAST_WDAY   = 3'd6;

    // Rounded-up reciprocals of 400 and 7, scaled by 2^RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] RECIP_CYCLE = 19'd5243;
    localparam logic [RECIP_W-1:0] RECIP_WEEK  = 19'd299594;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MOD,
        ST_EMIT
    } t_state;

    // Request to, and response from, the shared remainder unit.
    typedef struct packed {
        logic              start;
        logic [YEAR_W-1:0] dividend;
        logic [REM_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_mod_rsp;

    // Request that starts the day generator.
    typedef struct packed {
        logic              start;
        logic [WDAY_W-1:0] first;
        logic [DAY_W-1:0]  len;
        logic              leap;
    } t_gen_req;

    // Weekday shift of the 1st of a month relative to 1 January.
    function automatic logic [WDAY_W-1:0] f_first_offset(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [WDAY_W-1:0] off;
        unique case (month)
            4'd0:    off = 3'd0;
            4'd1:    off = 3'd3;
            4'd2:    off = leap ? 3'd4 : 3'd3;
            4'd3:    off = leap ? 3'd0 : 3'd6;
            4'd4:    off = leap ? 3'd2 : 3'd1;
            4'd5:    off = leap ? 3'd5 : 3'd4;
            4'd6:    off = leap ? 3'd0 : 3'd6;
            4'd7:    off = leap ? 3'd3 : 3'd2;
            4'd8:    off = leap ? 3'd6 : 3'd5;
            4'd9:    off = leap ? 3'd1 : 3'd0;
            4'd10:   off = leap ? 3'd4 : 3'd3;
            4'd11:   off = leap ? 3'd6 : 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Number of days in a month.
    function automatic logic [DAY_W-1:0] f_month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Remainder by 100 of a value below 400.
    function automatic logic [6:0] f_mod100(input logic [REM_W-1:0] v);
        logic [REM_W-1:0] r;
        if (v >= 9'd300) begin
            r = v - 9'd300;
        end else if (v >= 9'd200) begin
            r = v - 9'd200;
        end else if (v >= 9'd100) begin
            r = v - 9'd100;
        end else begin
            r = v;
        end
        return r[6:0];
    endfunction

endpackage

// File: hw/rtl/mcl_mod_unit.sv
// Shared remainder unit: reciprocal multiplication, then multiply back and subtract.
// Depends on mcl_pkg for widths, reciprocals and the request and response structs.
`timescale 1ns / 1ps

module mcl_mod_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcl_pkg::t_mod_req i_req,
    output mcl_pkg::t_mod_rsp o_rsp
);

    logic [mcl_pkg::YEAR_W-1:0]  r_val;
    logic [mcl_pkg::REM_W-1:0]   r_divisor;
    logic [mcl_pkg::RECIP_W-1:0] r_recip;
    logic [mcl_pkg::QUOT_W-1:0]  r_quot;
    logic [mcl_pkg::REM_W-1:0]   r_rem;
    logic                        r_mul;
    logic                        r_sub;
    logic                        r_done;

    logic [mcl_pkg::RECIP_W-1:0]                 recip;
    logic [mcl_pkg::YEAR_W+mcl_pkg::RECIP_W-1:0] prod;
    logic [mcl_pkg::QUOT_W+mcl_pkg::REM_W-1:0]   back;
    logic [mcl_pkg::YEAR_W-1:0]                  diff;

    // Reciprocal for the requested divisor. Only the year cycle and the week are used.
    assign recip = (i_req.divisor == mcl_pkg::CYCLE_DAYS) ? mcl_pkg::RECIP_CYCLE
                                                          : mcl_pkg::RECIP_WEEK;

    // Quotient by reciprocal multiplication, remainder by multiplying back.
    always_comb begin
        prod = {{mcl_pkg::RECIP_W{1'b0}}, r_val} * {{mcl_pkg::YEAR_W{1'b0}}, r_recip};
        back = {{mcl_pkg::REM_W{1'b0}}, r_quot} * {{mcl_pkg::QUOT_W{1'b0}}, r_divisor};
        diff = r_val - back[mcl_pkg::YEAR_W-1:0];
    end

    // Control: a start is followed by the multiply step, the subtract step and done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_req.start;
            r_sub  <= r_mul;
            r_done <= r_sub;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_recip   <= recip;
        end
        if (r_mul) begin
            r_quot <= prod[mcl_pkg::RECIP_SHIFT +: mcl_pkg::QUOT_W];
        end
        if (r_sub) begin
            r_rem <= diff[mcl_pkg::REM_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// File: hw/rtl/mcl_day_gen.sv
// Day generator: walks the days of a month and holds the result register.
// Depends on mcl_pkg for widths and the start request struct.
`timescale 1ns / 1ps

module mcl_day_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcl_pkg::t_gen_req           i_req,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [mcl_pkg::DAY_W-1:0]   o_day,
    output logic [mcl_pkg::WDAY_W-1:0]  o_weekday,
    output logic [mcl_pkg::ROW_W-1:0]   o_row,
    output logic [mcl_pkg::DAY_W-1:0]   o_month_length,
    output logic                        o_leap_year,
    output logic                        o_last,
    output logic                        o_done
);

    logic                       r_valid;
    logic [mcl_pkg::DAY_W-1:0]  r_day;
    logic [mcl_pkg::WDAY_W-1:0] r_weekday;
    logic [mcl_pkg::ROW_W-1:0]  r_row;
    logic [mcl_pkg::DAY_W-1:0]  r_len;
    logic                       r_leap;

    logic take;
    logic last;

    assign take = r_valid && i_ready;
    assign last = (r_day == r_len);

    // Valid flag: set on start, cleared when the final day is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_valid <= 1'b1;
        end else if (take && last) begin
            r_valid <= 1'b0;
        end
    end

    // Grid position advances by one cell for each transaction taken.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_day     <= mcl_pkg::DAY_W'(1);
            r_weekday <= i_req.first;
            r_row     <= '0;
            r_len     <= i_req.len;
            r_leap    <= i_req.leap;
        end else if (take) begin
            r_day <= r_day + 1'b1;
            if (r_weekday == mcl_pkg::LAST_WDAY) begin
                r_weekday <= '0;
                r_row     <= r_row + 1'b1;
            end else begin
                r_weekday <= r_weekday + 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_day          = r_day;
    assign o_weekday      = r_weekday;
    assign o_row          = r_row;
    assign o_month_length = r_len;
    assign o_leap_year    = r_leap;
    assign o_last         = last;
    assign o_done         = take && last;

endmodule

// File: hw/rtl/month_calendar_layout.sv
// Top level of the month calendar layout block: sequencer and weekday arithmetic.
// Depends on mcl_pkg, mcl_mod_unit and mcl_day_gen.
`timescale 1ns / 1ps

// Usage
// An input transaction (i_year, i_month) is taken when i_valid and o_ready are
// both high. For a month index of 12 or more the transaction is dropped and
// the block is ready again in the next cycle. Otherwise the block emits one
// output transaction per day of the month, in order, on o_valid and i_ready,
// with o_last marking the final day.
// The shared remainder unit works in steps (load, reciprocal multiply, multiply
// back and subtract), first for the year modulo 400 and again for the weekday
// modulo 7; the sequencer hands over between the two through ST_PREP, and the
// weekday result starts the day generator.
// A new item is not taken while the previous one is in flight: o_ready is high
// only between items.
// A stalling receiver holds the current day in the output register; the
// block simply waits. Reset returns the sequencer to idle and drops any
// pending output.
module month_calendar_layout (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mcl_pkg::YEAR_W-1:0]    i_year,
    input  logic [mcl_pkg::MONTH_W-1:0]   i_month,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mcl_pkg::DAY_W-1:0]     o_day,
    output logic [mcl_pkg::WDAY_W-1:0]    o_weekday,
    output logic [mcl_pkg::ROW_W-1:0]     o_row,
    output logic [mcl_pkg::DAY_W-1:0]     o_month_length,
    output logic                          o_leap_year,
    output logic                          o_last
);

    mcl_pkg::t_state r_state;
    mcl_pkg::t_state n_state;

    logic [mcl_pkg::MONTH_W-1:0] r_month;
    logic [1:0]                  r_year_lo;
    logic                        r_leap;
    logic [mcl_pkg::DAY_W-1:0]   r_len;

    mcl_pkg::t_mod_req mod_req;
    mcl_pkg::t_mod_rsp mod_rsp;
    mcl_pkg::t_gen_req gen_req;
    logic              gen_done;

    logic        accept;
    logic        month_ok;
    logic [8:0]  rem400;
    logic [8:0]  prev400;
    logic [6:0]  prev100;
    logic [1:0]  prev4;
    logic        leap;
    logic [13:0] wsum;

    assign accept   = i_valid && o_ready;
    assign month_ok = (i_month <= mcl_pkg::LAST_MONTH);

    // Leap year and weekday sum from the year modulo 400. The previous year
    // modulo 4, 100 and 400 feed the standard weekday formula for 1 January.
    always_comb begin
        rem400  = mod_rsp.rem;
        leap    = ((r_year_lo == 2'd0) && (mcl_pkg::f_mod100(rem400) != 7'd0))
                  || (rem400 == 9'd0);
        prev400 = (rem400 == 9'd0) ? 9'd399 : (rem400 - 9'd1);
        prev100 = mcl_pkg::f_mod100(prev400);
        prev4   = r_year_lo - 2'd1;
        wsum    = 14'd1
                  + 14'd5 * 14'(prev4)
                  + 14'd4 * 14'(prev100)
                  + 14'd6 * 14'(prev400)
                  + 14'(mcl_pkg::f_first_offset(r_month, leap));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcl_pkg::ST_IDLE: begin
                if (accept && month_ok) begin
                    n_state = mcl_pkg::ST_DIV;
                end
            end
            mcl_pkg::ST_DIV: begin
                if (mod_rsp.done) begin
                    n_state = mcl_pkg::ST_PREP;
                end
            end
            mcl_pkg::ST_PREP: begin
                n_state = mcl_pkg::ST_MOD;
            end
            mcl_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    n_state = mcl_pkg::ST_EMIT;
                end
            end
            mcl_pkg::ST_EMIT: begin
                if (gen_done) begin
                    n_state = mcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcl_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake and requests to the remainder unit and the day generator.
    always_comb begin
        o_ready          = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = i_year;
        mod_req.divisor  = mcl_pkg::CYCLE_DAYS;
        gen_req.start    = 1'b0;
        gen_req.first    = mod_rsp.rem[mcl_pkg::WDAY_W-1:0];
        gen_req.len      = r_len;
        gen_req.leap     = r_leap;
        unique case (r_state)
            mcl_pkg::ST_IDLE: begin
                o_ready       = 1'b1;
                mod_req.start = accept && month_ok;
            end
            mcl_pkg::ST_PREP: begin
                mod_req.start    = 1'b1;
                mod_req.dividend = wsum;
                mod_req.divisor  = mcl_pkg::WEEK_DAYS;
            end
            mcl_pkg::ST_MOD: begin
                gen_req.start = mod_rsp.done;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item registers: captured on the input transaction and after the year step.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_month   <= i_month;
            r_year_lo <= i_year[1:0];
        end
        if (r_state == mcl_pkg::ST_PREP) begin
            r_leap <= leap;
            r_len  <= mcl_pkg::f_month_days(r_month, leap);
        end
    end

    mcl_mod_unit u_mod_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    mcl_day_gen u_day_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (gen_req),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_day          (o_day),
        .o_weekday      (o_weekday),
        .o_row          (o_row),
        .o_month_length (o_month_length),
        .o_leap_year    (o_leap_year),
        .o_last         (o_last),
        .o_done         (gen_done)
    );

endmodule
